/* rtl/core/cfpos_pkg.sv */
// ----------------------------------------------------------------------------
// cfpos_pkg
// Shared types, constants and helper functions for the port output scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package cfpos_pkg;

  // sizing
  localparam int MAX_NETWORKS = 4;
  localparam int MAX_CHANNELS = 8;
  localparam int QUEUE_DEPTH  = 16;
  localparam int NET_W        = 2;
  localparam int CHAN_W       = 3;
  localparam int Q_W          = NET_W + CHAN_W;
  localparam int NQ           = MAX_NETWORKS * MAX_CHANNELS;
  localparam int SLOT_W       = 4;
  localparam int FILL_W       = 5;
  localparam int MEM_AW       = Q_W + SLOT_W;
  localparam int NN_W         = 3;
  localparam int NC_W         = 4;
  localparam int OS_W         = 5;
  localparam int TAG_W        = 32;
  localparam int CRED_W       = 8;
  localparam int SPACE_W      = 4;
  localparam int CFG_W        = 5;
  localparam int CFG_IDX_W    = 2;

  // input item codes
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_CREDIT = 2'd1;
  localparam logic [1:0] FUNC_ENQ    = 2'd2;
  localparam logic [1:0] FUNC_DEQ    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NETS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS = 2'd2;

  // result kinds
  localparam logic RES_FLIT   = 1'b0;
  localparam logic RES_CREDIT = 1'b1;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TICK,
    OP_CREDIT,
    OP_ENQ,
    OP_DEQ
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_SEND,
    ST_RET
  } eng_state_t;

  // clamped configuration
  typedef struct packed {
    logic [NN_W-1:0] nets;
    logic [NC_W-1:0] chans;
    logic [OS_W-1:0] slots;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [NET_W-1:0]   net;
    logic [CHAN_W-1:0]  chan;
    logic [CRED_W-1:0]  cnt;
    logic [TAG_W-1:0]   tag;
    logic [SPACE_W-1:0] space;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic [NET_W-1:0]   net;
    logic [CHAN_W-1:0]  chan;
    logic [TAG_W-1:0]   tag;
    logic [CRED_W-1:0]  cred;
    logic               last;
  } result_t;

  // (ptr + 1) mod nets, for narrow values
  function automatic logic [NET_W-1:0] inc_wrap_net(input logic [NET_W-1:0] ptr,
                                                    input logic [NN_W-1:0] nets);
    logic [NN_W-1:0] s;
    s = NN_W'(ptr) + NN_W'(1);
    for (int i = 0; i < MAX_NETWORKS; i++) begin
      if (s >= nets) begin
        s = s - nets;
      end
    end
    return s[NET_W-1:0];
  endfunction

  // (ptr + 1) mod chans, for narrow values
  function automatic logic [CHAN_W-1:0] inc_wrap_chan(input logic [CHAN_W-1:0] ptr,
                                                      input logic [NC_W-1:0] chans);
    logic [NC_W-1:0] s;
    s = NC_W'(ptr) + NC_W'(1);
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (s >= chans) begin
        s = s - chans;
      end
    end
    return s[CHAN_W-1:0];
  endfunction

  // round-robin pick over channel flags; msb is the found flag
  function automatic logic [CHAN_W:0] rr_pick_chan(input logic [MAX_CHANNELS-1:0] flags,
                                                   input logic [CHAN_W-1:0] start);
    logic              found;
    logic [CHAN_W-1:0] idx;
    logic [CHAN_W-1:0] sel;
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      idx = start + CHAN_W'(i);
      if (!found && flags[idx]) begin
        found = 1'b1;
        sel   = idx;
      end
    end
    return {found, sel};
  endfunction

  // round-robin pick over network flags; msb is the found flag
  function automatic logic [NET_W:0] rr_pick_net(input logic [MAX_NETWORKS-1:0] flags,
                                                 input logic [NET_W-1:0] start);
    logic             found;
    logic [NET_W-1:0] idx;
    logic [NET_W-1:0] sel;
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < MAX_NETWORKS; i++) begin
      idx = start + NET_W'(i);
      if (!found && flags[idx]) begin
        found = 1'b1;
        sel   = idx;
      end
    end
    return {found, sel};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/cfpos_front.sv */
// ----------------------------------------------------------------------------
// cfpos_front
// Accepts input items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpos_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [1:0]                       func,
  input  wire logic [cfpos_pkg::NET_W-1:0]      net_index,
  input  wire logic [cfpos_pkg::CHAN_W-1:0]     chan_index,
  input  wire logic [cfpos_pkg::CRED_W-1:0]     credit_count,
  input  wire logic [cfpos_pkg::TAG_W-1:0]      flit_tag,
  input  wire logic [cfpos_pkg::SPACE_W-1:0]    link_space,
  input  wire cfpos_pkg::cfg_t                  cfg,
  output logic                                  cmd_valid,
  output cfpos_pkg::cmd_t                       cmd,
  input  wire logic                             cmd_pop
);

  cfpos_pkg::cmd_t cls;
  cfpos_pkg::cmd_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            in_range;
  logic            do_push;
  logic            do_pop;

  // classify: out-of-range addressing turns into a no-op
  always_comb begin
    in_range = ({1'b0, net_index} < cfg.nets) && ({1'b0, chan_index} < cfg.chans);
    cls.net   = net_index;
    cls.chan  = chan_index;
    cls.cnt   = credit_count;
    cls.tag   = flit_tag;
    cls.space = link_space;
    case (func)
      cfpos_pkg::FUNC_TICK:   cls.op = cfpos_pkg::OP_TICK;
      cfpos_pkg::FUNC_CREDIT: cls.op = in_range ? cfpos_pkg::OP_CREDIT : cfpos_pkg::OP_NONE;
      cfpos_pkg::FUNC_ENQ:    cls.op = in_range ? cfpos_pkg::OP_ENQ : cfpos_pkg::OP_NONE;
      cfpos_pkg::FUNC_DEQ:    cls.op = in_range ? cfpos_pkg::OP_DEQ : cfpos_pkg::OP_NONE;
      default:                cls.op = cfpos_pkg::OP_NONE;
    endcase
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cfpos_res_queue.sv */
// ----------------------------------------------------------------------------
// cfpos_res_queue
// Four-entry result queue between the engine and the result ports.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpos_res_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire cfpos_pkg::result_t wr_data,
  output logic                   res_full,
  output logic                   empty,
  input  wire logic              pop,
  output cfpos_pkg::result_t     rd_data
);

  cfpos_pkg::result_t slots [4];
  logic [1:0]         wr_ptr;
  logic [1:0]         rd_ptr;
  logic [2:0]         count;
  logic               do_push;
  logic               do_pop;

  assign res_full = (count == 3'd4);
  assign empty    = (count == 3'd0);
  assign rd_data  = slots[rd_ptr];
  assign do_push  = wr_en && !res_full;
  assign do_pop   = pop && !empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 2'd1;
      if (do_pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(do_push) - 3'(do_pop);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cfpos_engine.sv */
// ----------------------------------------------------------------------------
// cfpos_engine
// Back end: owns queue state, credits and tag memory; runs the tick scans.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpos_engine (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfpos_pkg::cfg_t    cfg,
  input  wire logic               cmd_valid,
  input  wire cfpos_pkg::cmd_t    cmd,
  output logic                    cmd_pop,
  output logic                    res_push,
  output cfpos_pkg::result_t      res_data,
  input  wire logic               res_full
);

  localparam int NETS  = cfpos_pkg::MAX_NETWORKS;
  localparam int CHANS = cfpos_pkg::MAX_CHANNELS;

  cfpos_pkg::eng_state_t state;
  cfpos_pkg::eng_state_t state_next;

  // per-queue state
  logic [cfpos_pkg::FILL_W-1:0] fill  [cfpos_pkg::NQ];
  logic [cfpos_pkg::SLOT_W-1:0] head  [cfpos_pkg::NQ];
  logic [cfpos_pkg::CRED_W-1:0] dcred [cfpos_pkg::NQ];
  logic [cfpos_pkg::CRED_W-1:0] owed  [cfpos_pkg::NQ];
  logic [cfpos_pkg::TAG_W-1:0]  mem   [2**cfpos_pkg::MEM_AW];

  logic [cfpos_pkg::NET_W-1:0]  send_net_ptr;
  logic [cfpos_pkg::CHAN_W-1:0] send_chan_ptr;
  logic [cfpos_pkg::NET_W-1:0]  return_net_ptr;
  logic [cfpos_pkg::CHAN_W-1:0] return_chan_ptr;

  // tick working registers
  logic [cfpos_pkg::SPACE_W-1:0] space;
  logic [cfpos_pkg::Q_W-1:0]     sel_q;
  logic [cfpos_pkg::MEM_AW-1:0]  rd_addr;
  logic [cfpos_pkg::TAG_W-1:0]   rd_tag;
  logic [NETS-1:0]               ret_mask;
  logic [cfpos_pkg::CHAN_W-1:0]  ret_chan [NETS];
  logic [cfpos_pkg::NET_W-1:0]   rn_cur;

  // scan results
  logic [CHANS-1:0]              send_elig [NETS];
  logic [CHANS-1:0]              owe_elig  [NETS];
  logic [NETS-1:0]               net_has;
  logic [cfpos_pkg::CHAN_W-1:0]  send_chan [NETS];
  logic [cfpos_pkg::CHAN_W:0]    cpick;
  logic [cfpos_pkg::CHAN_W:0]    rpick;
  logic [cfpos_pkg::NET_W:0]     npick;
  logic [NETS-1:0]               ret_found;
  logic [cfpos_pkg::CHAN_W-1:0]  ret_pick [NETS];
  logic [cfpos_pkg::NET_W-1:0]   vn0;
  logic [cfpos_pkg::CHAN_W-1:0]  c0;
  logic [cfpos_pkg::NET_W-1:0]   rn0;
  logic [cfpos_pkg::CHAN_W-1:0]  r0;
  logic                          send_found;
  logic [cfpos_pkg::Q_W-1:0]     send_q;

  // command-side helpers
  logic [cfpos_pkg::Q_W-1:0]     cq;
  logic [cfpos_pkg::CRED_W:0]    cred_sum;
  logic                          enq_ok;
  logic [cfpos_pkg::SLOT_W-1:0]  enq_slot;
  logic [cfpos_pkg::Q_W-1:0]     ret_q;
  logic [NETS-1:0]               rn_bit;
  logic                          ret_push;

  assign cq       = {cmd.net, cmd.chan};
  assign cred_sum = {1'b0, dcred[cq]} + {1'b0, cmd.cnt};
  assign enq_ok   = {1'b0, fill[cq]} < {1'b0, cfg.slots};
  assign enq_slot = head[cq] + fill[cq][cfpos_pkg::SLOT_W-1:0];
  assign ret_q    = {rn_cur, ret_chan[rn_cur]};
  assign rn_bit   = NETS'(1) << rn_cur;

  // scan start points, falling back to zero beyond the active counts
  always_comb begin
    vn0 = ({1'b0, send_net_ptr} < cfg.nets) ? send_net_ptr : '0;
    c0  = ({1'b0, send_chan_ptr} < cfg.chans) ? send_chan_ptr : '0;
    rn0 = ({1'b0, return_net_ptr} < cfg.nets) ? return_net_ptr : '0;
    r0  = ({1'b0, return_chan_ptr} < cfg.chans) ? return_chan_ptr : '0;
  end

  // eligibility flags and per-network round-robin picks
  always_comb begin
    for (int n = 0; n < NETS; n++) begin
      for (int c = 0; c < CHANS; c++) begin
        send_elig[n][c] = (fill[n*CHANS+c] != '0) && (dcred[n*CHANS+c] != '0) &&
                          (n < int'(cfg.nets)) && (c < int'(cfg.chans)) && space[n];
        owe_elig[n][c]  = (owed[n*CHANS+c] != '0) &&
                          (n < int'(cfg.nets)) && (c < int'(cfg.chans));
      end
      cpick        = cfpos_pkg::rr_pick_chan(send_elig[n], c0);
      net_has[n]   = cpick[cfpos_pkg::CHAN_W];
      send_chan[n] = cpick[cfpos_pkg::CHAN_W-1:0];
      rpick        = cfpos_pkg::rr_pick_chan(owe_elig[n], r0);
      ret_found[n] = rpick[cfpos_pkg::CHAN_W];
      ret_pick[n]  = rpick[cfpos_pkg::CHAN_W-1:0];
    end
    npick      = cfpos_pkg::rr_pick_net(net_has, vn0);
    send_found = npick[cfpos_pkg::NET_W];
    send_q     = {npick[cfpos_pkg::NET_W-1:0], send_chan[npick[cfpos_pkg::NET_W-1:0]]};
  end

  // next state and handshakes
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    ret_push   = 1'b0;
    res_data   = '0;
    case (state)
      cfpos_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.op == cfpos_pkg::OP_TICK) state_next = cfpos_pkg::ST_SCAN;
        end
      end
      cfpos_pkg::ST_SCAN: begin
        if (send_found)           state_next = cfpos_pkg::ST_READ;
        else if (ret_found != '0) state_next = cfpos_pkg::ST_RET;
        else                      state_next = cfpos_pkg::ST_IDLE;
      end
      cfpos_pkg::ST_READ: begin
        state_next = cfpos_pkg::ST_SEND;
      end
      cfpos_pkg::ST_SEND: begin
        res_data.kind = cfpos_pkg::RES_FLIT;
        res_data.net  = sel_q[cfpos_pkg::Q_W-1:cfpos_pkg::CHAN_W];
        res_data.chan = sel_q[cfpos_pkg::CHAN_W-1:0];
        res_data.tag  = rd_tag;
        res_data.last = 1'b1;
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = cfpos_pkg::ST_IDLE;
        end
      end
      cfpos_pkg::ST_RET: begin
        res_data.kind = cfpos_pkg::RES_CREDIT;
        res_data.net  = rn_cur;
        res_data.chan = ret_chan[rn_cur];
        res_data.cred = owed[ret_q];
        res_data.last = ((ret_mask & ~rn_bit) == '0);
        if (ret_mask[rn_cur] && !res_full) begin
          res_push = 1'b1;
          ret_push = 1'b1;
          if ((ret_mask & ~rn_bit) == '0) state_next = cfpos_pkg::ST_IDLE;
        end
      end
      default: state_next = cfpos_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfpos_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // counters, pointers and scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < cfpos_pkg::NQ; q++) begin
        fill[q]  <= '0;
        head[q]  <= '0;
        dcred[q] <= '0;
        owed[q]  <= '0;
      end
      send_net_ptr    <= '0;
      send_chan_ptr   <= '0;
      return_net_ptr  <= '0;
      return_chan_ptr <= '0;
      ret_mask        <= '0;
    end else begin
      case (state)
        cfpos_pkg::ST_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              cfpos_pkg::OP_CREDIT: begin
                dcred[cq] <= cred_sum[cfpos_pkg::CRED_W] ? '1 :
                             cred_sum[cfpos_pkg::CRED_W-1:0];
              end
              cfpos_pkg::OP_ENQ: begin
                if (enq_ok) fill[cq] <= fill[cq] + 1'b1;
              end
              cfpos_pkg::OP_DEQ: begin
                if (owed[cq] != '1) owed[cq] <= owed[cq] + 1'b1;
              end
              cfpos_pkg::OP_TICK: begin
                space <= cmd.space;
              end
              default: begin
              end
            endcase
          end
        end
        cfpos_pkg::ST_SCAN: begin
          send_net_ptr  <= cfpos_pkg::inc_wrap_net(send_net_ptr, cfg.nets);
          send_chan_ptr <= cfpos_pkg::inc_wrap_chan(send_chan_ptr, cfg.chans);
          if (send_found) begin
            sel_q         <= send_q;
            rd_addr       <= {send_q, head[send_q]};
            head[send_q]  <= head[send_q] + 1'b1;
            fill[send_q]  <= fill[send_q] - 1'b1;
            dcred[send_q] <= dcred[send_q] - 1'b1;
          end else begin
            return_net_ptr  <= cfpos_pkg::inc_wrap_net(return_net_ptr, cfg.nets);
            return_chan_ptr <= cfpos_pkg::inc_wrap_chan(return_chan_ptr, cfg.chans);
            ret_mask        <= ret_found;
            rn_cur          <= rn0;
            for (int n = 0; n < NETS; n++) begin
              ret_chan[n] <= ret_pick[n];
            end
          end
        end
        cfpos_pkg::ST_RET: begin
          // walk networks in order, skipping those with nothing owed
          if (!ret_mask[rn_cur] || ret_push) begin
            rn_cur <= ({1'b0, rn_cur} + 1'b1 == cfg.nets) ? '0 : rn_cur + 1'b1;
          end
          if (ret_push) begin
            owed[ret_q] <= '0;
            ret_mask    <= ret_mask & ~rn_bit;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // tag memory: write on enqueue, registered read for the send path
  always_ff @(posedge clk) begin
    if (state == cfpos_pkg::ST_IDLE && cmd_valid && cmd.op == cfpos_pkg::OP_ENQ && enq_ok) begin
      mem[{cq, enq_slot}] <= cmd.tag;
    end
    if (state == cfpos_pkg::ST_READ) begin
      rd_tag <= mem[rd_addr];
    end
  end

  // a flit result always follows a memory read
  a_send_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == cfpos_pkg::ST_SEND) |-> ($past(state) == cfpos_pkg::ST_READ ||
                                       $past(state) == cfpos_pkg::ST_SEND))
    else $error("send state entered without a tag read");

  // never push into a full result queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(res_push && res_full))
    else $error("result pushed while queue full");

  // a credit return only comes from a network still marked as owing
  a_ret_marked: assert property (@(posedge clk) disable iff (rst)
    (ret_push) |-> ret_mask[rn_cur])
    else $error("credit returned for unmarked network");

  // the return walk ends once every marked network is served
  a_ret_done: assert property (@(posedge clk) disable iff (rst)
    (state == cfpos_pkg::ST_RET && ret_push && res_data.last) |=>
      (state == cfpos_pkg::ST_IDLE && ret_mask == '0))
    else $error("return walk did not finish after last result");

endmodule

`default_nettype wire

/* rtl/core/credit_flow_port_output_scheduler.sv */
// ----------------------------------------------------------------------------
// credit_flow_port_output_scheduler
// Router port output side with credit flow control and round-robin scheduling.
// ----------------------------------------------------------------------------
// Flow: a credit, enqueue or dequeue item waits in the front queue and takes
// effect when the idle engine pops it; a tick goes through scan, read and
// send to put a flit in the result queue. The engine retires one non-tick item
// per cycle while idle; a tick holds it for the scan, then any send or return.
// Reset: synchronous; clears counts, pointers and queues; tag storage is
// left as is and needs no clearing pass.
`default_nettype none

module credit_flow_port_output_scheduler (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration write port
  input  wire logic                             cfg_we,
  input  wire logic [cfpos_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cfpos_pkg::CFG_W-1:0]      cfg_data,
  // input items
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [1:0]                       func,
  input  wire logic [cfpos_pkg::NET_W-1:0]      net_index,
  input  wire logic [cfpos_pkg::CHAN_W-1:0]     chan_index,
  input  wire logic [cfpos_pkg::CRED_W-1:0]     credit_count,
  input  wire logic [cfpos_pkg::TAG_W-1:0]      flit_tag,
  input  wire logic [cfpos_pkg::SPACE_W-1:0]    link_space,
  // results
  output logic                                  empty,
  input  wire logic                             pop,
  output logic                                  result_kind,
  output logic [cfpos_pkg::NET_W-1:0]           out_net,
  output logic [cfpos_pkg::CHAN_W-1:0]          out_chan,
  output logic [cfpos_pkg::TAG_W-1:0]           sent_tag,
  output logic [cfpos_pkg::CRED_W-1:0]          returned_credits,
  output logic                                  last_result
);

  logic [cfpos_pkg::NN_W-1:0] networks_in_use;
  logic [cfpos_pkg::NC_W-1:0] channels_in_use;
  logic [cfpos_pkg::OS_W-1:0] output_slots;
  cfpos_pkg::cfg_t            cfg;
  logic                       cmd_valid;
  cfpos_pkg::cmd_t            cmd;
  logic                       cmd_pop;
  logic                       res_push;
  cfpos_pkg::result_t         res_in;
  cfpos_pkg::result_t         res_out;
  logic                       res_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      networks_in_use <= cfpos_pkg::NN_W'(cfpos_pkg::MAX_NETWORKS);
      channels_in_use <= cfpos_pkg::NC_W'(cfpos_pkg::MAX_CHANNELS);
      output_slots    <= cfpos_pkg::OS_W'(cfpos_pkg::QUEUE_DEPTH);
    end else if (cfg_we) begin
      case (cfg_index)
        cfpos_pkg::REG_NETS:  networks_in_use <= cfg_data[cfpos_pkg::NN_W-1:0];
        cfpos_pkg::REG_CHANS: channels_in_use <= cfg_data[cfpos_pkg::NC_W-1:0];
        cfpos_pkg::REG_SLOTS: output_slots    <= cfg_data[cfpos_pkg::OS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamp to the supported ranges
  always_comb begin
    if (networks_in_use == '0)
      cfg.nets = cfpos_pkg::NN_W'(1);
    else if (networks_in_use > cfpos_pkg::NN_W'(cfpos_pkg::MAX_NETWORKS))
      cfg.nets = cfpos_pkg::NN_W'(cfpos_pkg::MAX_NETWORKS);
    else
      cfg.nets = networks_in_use;
    if (channels_in_use == '0)
      cfg.chans = cfpos_pkg::NC_W'(1);
    else if (channels_in_use > cfpos_pkg::NC_W'(cfpos_pkg::MAX_CHANNELS))
      cfg.chans = cfpos_pkg::NC_W'(cfpos_pkg::MAX_CHANNELS);
    else
      cfg.chans = channels_in_use;
    if (output_slots > cfpos_pkg::OS_W'(cfpos_pkg::QUEUE_DEPTH))
      cfg.slots = cfpos_pkg::OS_W'(cfpos_pkg::QUEUE_DEPTH);
    else
      cfg.slots = output_slots;
  end

  cfpos_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .func         (func),
    .net_index    (net_index),
    .chan_index   (chan_index),
    .credit_count (credit_count),
    .flit_tag     (flit_tag),
    .link_space   (link_space),
    .cfg          (cfg),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  cfpos_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_in),
    .res_full  (res_full)
  );

  cfpos_res_queue u_res_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (res_push),
    .wr_data  (res_in),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .rd_data  (res_out)
  );

  assign result_kind      = res_out.kind;
  assign out_net          = res_out.net;
  assign out_chan         = res_out.chan;
  assign sent_tag         = res_out.tag;
  assign returned_credits = res_out.cred;
  assign last_result      = res_out.last;

endmodule

`default_nettype wire

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the port output scheduler: random and directed
// credit, enqueue, dequeue and tick items against a behavioral predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  typedef struct packed {
    logic [1:0]                    fn;
    logic [cfpos_pkg::NET_W-1:0]   net;
    logic [cfpos_pkg::CHAN_W-1:0]  chan;
    logic [cfpos_pkg::CRED_W-1:0]  cnt;
    logic [cfpos_pkg::TAG_W-1:0]   tag;
    logic [cfpos_pkg::SPACE_W-1:0] space;
  } item_t;

  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [cfpos_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cfpos_pkg::CFG_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full, empty;
  logic pop = 1'b0;
  logic [1:0] func = '0;
  logic [cfpos_pkg::NET_W-1:0] net_index = '0;
  logic [cfpos_pkg::CHAN_W-1:0] chan_index = '0;
  logic [cfpos_pkg::CRED_W-1:0] credit_count = '0;
  logic [cfpos_pkg::TAG_W-1:0] flit_tag = '0;
  logic [cfpos_pkg::SPACE_W-1:0] link_space = '0;
  logic result_kind, last_result;
  logic [cfpos_pkg::NET_W-1:0] out_net;
  logic [cfpos_pkg::CHAN_W-1:0] out_chan;
  logic [cfpos_pkg::TAG_W-1:0] sent_tag;
  logic [cfpos_pkg::CRED_W-1:0] returned_credits;

  credit_flow_port_output_scheduler dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [cfpos_pkg::NN_W-1:0] p_nets;
  logic [cfpos_pkg::NC_W-1:0] p_chans;
  logic [cfpos_pkg::OS_W-1:0] p_slots;
  logic [cfpos_pkg::TAG_W-1:0] p_tags [cfpos_pkg::NQ][cfpos_pkg::QUEUE_DEPTH];
  int p_fill [cfpos_pkg::NQ];
  int p_head [cfpos_pkg::NQ];
  int p_down [cfpos_pkg::NQ];
  int p_owed [cfpos_pkg::NQ];
  int p_snet, p_schan, p_rnet, p_rchan;

  item_t pending_items[$];
  cfpos_pkg::result_t expected_results[$];
  int send_idle = 7, recv_idle = 76;
  int hold_cycles = 0;
  logic hold_recv;
  bit failed = 0;
  int quiet = 0;

  function automatic int act_nets();
    return p_nets < 1 ? 1 : (p_nets > cfpos_pkg::MAX_NETWORKS ? cfpos_pkg::MAX_NETWORKS
                                                                : int'(p_nets));
  endfunction

  function automatic int act_chans();
    return p_chans < 1 ? 1 : (p_chans > cfpos_pkg::MAX_CHANNELS ? cfpos_pkg::MAX_CHANNELS
                                                                 : int'(p_chans));
  endfunction

  // apply one accepted item to the predictor, queue its results
  function automatic void predict_item(item_t it);
    int nn, nc, q, vn, vc, c0, lim, n0;
    bit sent;
    cfpos_pkg::result_t r;
    cfpos_pkg::result_t res[$];
    nn = act_nets();
    nc = act_chans();
    if (it.fn != cfpos_pkg::FUNC_TICK) begin
      if (it.net >= nn || it.chan >= nc) return;
      q = it.net * cfpos_pkg::MAX_CHANNELS + it.chan;
      lim = p_slots > cfpos_pkg::QUEUE_DEPTH ? cfpos_pkg::QUEUE_DEPTH : int'(p_slots);
      case (it.fn)
        cfpos_pkg::FUNC_CREDIT:
          p_down[q] = (p_down[q] + it.cnt > 255) ? 255 : p_down[q] + it.cnt;
        cfpos_pkg::FUNC_ENQ: if (p_fill[q] < lim) begin
          p_tags[q][(p_head[q] + p_fill[q]) % cfpos_pkg::QUEUE_DEPTH] = it.tag;
          p_fill[q]++;
        end
        default: if (p_owed[q] < 255) p_owed[q]++;
      endcase
      return;
    end
    sent = 0;
    vn = p_snet < nn ? p_snet : 0;
    c0 = p_schan < nc ? p_schan : 0;
    for (int i = 0; i < nn && !sent; i++) begin
      vc = c0;
      for (int j = 0; j < nc && it.space[vn]; j++) begin
        q = vn * cfpos_pkg::MAX_CHANNELS + vc;
        if (p_fill[q] != 0 && p_down[q] != 0) begin
          r = '0;
          r.kind = cfpos_pkg::RES_FLIT;
          r.net = cfpos_pkg::NET_W'(vn);
          r.chan = cfpos_pkg::CHAN_W'(vc);
          r.tag = p_tags[q][p_head[q]];
          p_head[q] = (p_head[q] + 1) % cfpos_pkg::QUEUE_DEPTH;
          p_fill[q]--;
          p_down[q]--;
          res.push_back(r);
          sent = 1;
          break;
        end
        vc = (vc + 1 == nc) ? 0 : vc + 1;
      end
      vn = (vn + 1 == nn) ? 0 : vn + 1;
    end
    p_snet = (p_snet + 1) % nn;
    p_schan = (p_schan + 1) % nc;
    if (!sent) begin
      n0 = p_rnet < nn ? p_rnet : 0;
      c0 = p_rchan < nc ? p_rchan : 0;
      for (int i = 0; i < nn; i++) begin
        vc = c0;
        for (int j = 0; j < nc; j++) begin
          q = n0 * cfpos_pkg::MAX_CHANNELS + vc;
          if (p_owed[q] != 0) begin
            r = '0;
            r.kind = cfpos_pkg::RES_CREDIT;
            r.net = cfpos_pkg::NET_W'(n0);
            r.chan = cfpos_pkg::CHAN_W'(vc);
            r.cred = cfpos_pkg::CRED_W'(p_owed[q]);
            res.push_back(r);
            p_owed[q] = 0;
            break;
          end
          vc = (vc + 1 == nc) ? 0 : vc + 1;
        end
        n0 = (n0 + 1 == nn) ? 0 : n0 + 1;
      end
      p_rnet = (p_rnet + 1) % nn;
      p_rchan = (p_rchan + 1) % nc;
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[k]) expected_results.push_back(res[k]);
  endfunction

  // receiver hold-off, counted down in cycles
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end
  assign hold_recv = (hold_cycles != 0);

  // driver: offer the oldest pending item at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
        push <= 1'b1;
        func <= pending_items[0].fn;
        net_index <= pending_items[0].net;
        chan_index <= pending_items[0].chan;
        credit_count <= pending_items[0].cnt;
        flit_tag <= pending_items[0].tag;
        link_space <= pending_items[0].space;
      end else begin
        push <= 1'b0;
      end
      pop <= !hold_recv && ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor: predict on accepted inputs, check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        predict_item('{func, net_index, chan_index, credit_count, flit_tag, link_space});
        void'(pending_items.pop_front());
      end
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result: expected none, actual kind=%0d net=%0d chan=%0d",
                   $realtime, result_kind, out_net, out_chan);
          failed = 1;
        end else begin
          cfpos_pkg::result_t e;
          e = expected_results.pop_front();
          if (e != {result_kind, out_net, out_chan, sent_tag, returned_credits,
                    last_result}) begin
            $display("%0t result mismatch: expected kind=%0d net=%0d chan=%0d tag=%h cred=%0d last=%0d",
                     $realtime, e.kind, e.net, e.chan, e.tag, e.cred, e.last);
            $display("%0t   actual kind=%0d net=%0d chan=%0d tag=%h cred=%0d last=%0d",
                     $realtime, result_kind, out_net, out_chan, sent_tag,
                     returned_credits, last_result);
            failed = 1;
          end
        end
      end
      quiet = ((push && !full) || (pop && !empty)) ? 0 : quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic item_t mk(logic [1:0] f, int n, int c, int cnt, logic [31:0] tag,
                               int space);
    item_t it;
    it.fn = f;
    it.net = cfpos_pkg::NET_W'(n);
    it.chan = cfpos_pkg::CHAN_W'(c);
    it.cnt = cfpos_pkg::CRED_W'(cnt);
    it.tag = tag;
    it.space = cfpos_pkg::SPACE_W'(space);
    return it;
  endfunction

  // biased random item: mostly in range, ticks with mostly full link space
  function automatic item_t rand_item();
    int k, hi, n, c;
    logic [1:0] f;
    k = $urandom_range(99);
    f = k < 30 ? cfpos_pkg::FUNC_TICK :
        (k < 45 ? cfpos_pkg::FUNC_CREDIT :
        (k < 80 ? cfpos_pkg::FUNC_ENQ : cfpos_pkg::FUNC_DEQ));
    hi = act_nets() - 1;
    if ($urandom_range(9) == 0 && hi < 3) hi = hi + 1;
    n = $urandom_range(hi);
    c = ($urandom_range(7) < act_chans()) ? $urandom_range(act_chans() - 1)
                                          : $urandom_range(7);
    return mk(f, n, c, $urandom_range(9) == 0 ? 255 : $urandom_range(3), $urandom(),
              $urandom_range(3) == 0 ? $urandom_range(15) : 15);
  endfunction

  task automatic write_reg(logic [cfpos_pkg::CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= cfpos_pkg::CFG_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cfpos_pkg::REG_NETS: p_nets = cfpos_pkg::NN_W'(val);
      cfpos_pkg::REG_CHANS: p_chans = cfpos_pkg::NC_W'(val);
      default: p_slots = cfpos_pkg::OS_W'(val);
    endcase
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !push && expected_results.size() == 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic run_phase(int nets, int chans, int slots, int count);
    drain();
    write_reg(cfpos_pkg::REG_NETS, nets);
    write_reg(cfpos_pkg::REG_CHANS, chans);
    write_reg(cfpos_pkg::REG_SLOTS, slots);
    for (int i = 0; i < count; i++) pending_items.push_back(rand_item());
  endtask

  initial begin
    p_nets = 4;
    p_chans = 8;
    p_slots = 16;
    for (int q = 0; q < cfpos_pkg::NQ; q++) begin
      p_fill[q] = 0; p_head[q] = 0; p_down[q] = 0; p_owed[q] = 0;
    end
    p_snet = 0; p_schan = 0; p_rnet = 0; p_rchan = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, saturation, masked link
    pending_items.push_back(mk(cfpos_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(cfpos_pkg::FUNC_CREDIT, 3, 7, 255, 0, 0));
    pending_items.push_back(mk(cfpos_pkg::FUNC_CREDIT, 3, 7, 255, 0, 0));
    pending_items.push_back(mk(cfpos_pkg::FUNC_ENQ, 3, 7, 0, 32'hFFFF_FFFF, 0));
    pending_items.push_back(mk(cfpos_pkg::FUNC_ENQ, 3, 7, 0, 32'h0000_0000, 0));
    pending_items.push_back(mk(cfpos_pkg::FUNC_CREDIT, 0, 0, 1, 0, 0));
    pending_items.push_back(mk(cfpos_pkg::FUNC_ENQ, 0, 0, 0, 32'hA5A5_5A5A, 0));
    pending_items.push_back(mk(cfpos_pkg::FUNC_TICK, 0, 0, 0, 0, 4'b0111));
    pending_items.push_back(mk(cfpos_pkg::FUNC_TICK, 0, 0, 0, 0, 4'b1000));
    pending_items.push_back(mk(cfpos_pkg::FUNC_TICK, 0, 0, 0, 0, 4'b1111));
    pending_items.push_back(mk(cfpos_pkg::FUNC_TICK, 0, 0, 0, 0, 4'b1111));
    for (int n = 0; n < 4; n++)
      pending_items.push_back(mk(cfpos_pkg::FUNC_DEQ, n, 7 - 2 * n, 0, 0, 0));
    pending_items.push_back(mk(cfpos_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(cfpos_pkg::FUNC_TICK, 0, 0, 0, 0, 0));

    // random phases across settings, extremes included
    run_phase(1, 1, 1, 40);
    run_phase(0, 0, 0, 30);
    run_phase(7, 15, 31, 50);

    // long receiver hold-off while the sender keeps offering
    drain();
    hold_cycles = 600;
    for (int i = 0; i < 30; i++) begin
      pending_items.push_back(mk(cfpos_pkg::FUNC_DEQ, i % 4, i % 8, 0, 0, 0));
      pending_items.push_back(mk(cfpos_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
    end
    wait (hold_cycles == 0);

    drain();
    send_idle = 76;
    recv_idle = 7;
    run_phase(2, 3, 5, 50);
    run_phase(4, 8, 16, 50);
    drain();
    send_idle = 0;
    recv_idle = 0;
    run_phase(3, 5, 2, 40);
    run_phase(4, 8, 16, 40);

    drain();
    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/cfpos_pkg.sv
rtl/core/cfpos_front.sv
rtl/core/cfpos_res_queue.sv
rtl/core/cfpos_engine.sv
rtl/core/credit_flow_port_output_scheduler.sv
dv/tb.sv
